FILE: rtl/core/voxel_dda_sponge_raycaster_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel ray caster
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_DDA_SPONGE_RAYCASTER_ASSERT_SVH
`define VOXEL_DDA_SPONGE_RAYCASTER_ASSERT_SVH

// Property holds in the same cycle as its trigger
`define VDSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property holds in the cycle after its trigger
`define VDSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vdsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdsr_pkg
// Shared types, constants, trig table and voxel test for the ray caster.
// ----------------------------------------------------------------------------
package vdsr_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;
    localparam int MAX_STEPS     = 256;
    localparam int HALF_WIDTH    = SCREEN_WIDTH / 2;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

    localparam int COORD_W   = 11;
    localparam int FRAME_W   = 20;
    localparam int CNT_W     = 8;
    localparam int TRIG_W    = 12;
    localparam int TAB_DEPTH = 512;
    localparam int TAB_AW    = 9;
    localparam int VIEW_W    = 13;
    localparam int RAY_W     = 16;
    localparam int PROD_W    = RAY_W + TRIG_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int INV_W     = 19;
    localparam int TM_W      = 32;
    localparam int VOX_W     = 24;
    localparam int FX_SHIFT  = 10;
    localparam int CELL_SH   = 12;

    localparam int VIEW_Z     = 384;
    localparam int START_X    = 68 << 11;
    localparam int START_Y    = 12 << 11;
    localparam int CELL_ONE   = 1 << CELL_SH;
    localparam int RECIP_ZERO = (1 << 17) - 1;
    localparam int DIV_STEPS  = INV_W;
    localparam int TRIG_LAST  = 2;
    localparam int MUL_LAST   = 8;
    localparam int AXIS_LAST  = 2;
    localparam int NO_HIT     = 255;
    localparam int TEX_MASK   = 63;

    localparam longint Q_ONE     = 64'sh1000000000000000;
    localparam longint HALF_PI_Q = 64'sh1921FB54442D1847;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_TRIG  = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_TM    = 4'd5,
        OP_WALK  = 4'd6,
        OP_SHADE = 4'd7
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       axis;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic out_busy;
    } t_dp_status;

    typedef logic [2*TRIG_W-1:0] t_trig_rom [TAB_DEPTH];

    // signed Q60 product
    function automatic longint qmul(input longint a, input longint b);
        logic            neg;
        longint unsigned ua;
        longint unsigned ub;
        logic [127:0]    pr;
        longint unsigned rr;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        pr  = {64'd0, ua} * {64'd0, ub};
        rr  = pr[123:60];
        return neg ? -longint'(rr) : longint'(rr);
    endfunction

    // unsigned quotient by shift and subtract, table build only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        logic [64:0]     rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint trunc1024(input longint x);
        longint unsigned m;
        longint          r;
        m = (x < 0) ? 64'(-x) : 64'(x);
        r = longint'(m >> 50);
        return (x < 0) ? -r : r;
    endfunction

    // {cos, sin} scaled by 1024, truncated toward zero
    function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned v);
        longint unsigned n;
        longint unsigned nq;
        longint unsigned nr;
        longint unsigned rr;
        longint unsigned ta;
        longint          r;
        longint          c;
        longint          s;
        longint          t;
        longint          tp;
        longint          tq;
        longint          rc;
        longint          rs;
        longint          tc;
        longint          ts;
        int              q;
        int              k;
        n  = 64'd314159 * 64'(v & 32'd511);
        nq = udiv64(n, 64'd3125);
        nr = n - nq * 64'd3125;
        rr = (nq << 47) + udiv64(nr << 47, 64'd3125);
        r  = longint'(rr);
        c  = Q_ONE;
        s  = 0;
        t  = Q_ONE;
        q  = 0;
        while (r > (HALF_PI_Q >>> 1)) begin
            r = r - HALF_PI_Q;
            q = q + 1;
        end
        for (k = 1; k <= 22; k++) begin
            // quotient truncated toward zero
            tp = qmul(t, r);
            ta = (tp < 0) ? 64'(-tp) : 64'(tp);
            tq = longint'(udiv64(ta, 64'(k)));
            t  = (tp < 0) ? -tq : tq;
            case (k & 3)
                1: s = s + t;
                2: c = c - t;
                3: s = s - t;
                default: c = c + t;
            endcase
        end
        case (q & 3)
            0: begin rc = c;  rs = s;  end
            1: begin rc = -s; rs = c;  end
            2: begin rc = -c; rs = -s; end
            default: begin rc = s; rs = -c; end
        endcase
        tc = trunc1024(rc);
        ts = trunc1024(rs);
        return {tc[TRIG_W-1:0], ts[TRIG_W-1:0]};
    endfunction

    function automatic t_trig_rom build_rom();
        t_trig_rom rom;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            rom[i] = trig_entry(32'(i));
        end
        return rom;
    endfunction

    localparam t_trig_rom TRIG_ROM = build_rom();

    // solid when at each of three tile levels two or more coords sit on a face
    function automatic logic solid(input logic [VOX_W-1:0] x, input logic [VOX_W-1:0] y,
                                   input logic [VOX_W-1:0] z);
        logic       ok;
        logic [1:0] cx;
        logic [1:0] cy;
        logic [1:0] cz;
        logic [1:0] faces;
        ok = 1'b1;
        for (int l = 0; l < 3; l++) begin
            cx    = x[2*l +: 2];
            cy    = y[2*l +: 2];
            cz    = z[2*l +: 2];
            faces = 2'(cx == 2'd0 || cx == 2'd3) + 2'(cy == 2'd0 || cy == 2'd3)
                  + 2'(cz == 2'd0 || cz == 2'd3);
            if (faces < 2'd2) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: rtl/core/vdsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdsr_ctrl
// Sequencer: table reads, rotation products, reciprocals, traversal, shade.
// ----------------------------------------------------------------------------
module vdsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  vdsr_pkg::t_dp_status i_status,
    output vdsr_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TRIG  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_TM    = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_SHADE = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [vdsr_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]                  r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_axis     = r_axis;
        o_cmd.op   = vdsr_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_cmd.cnt  = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = vdsr_pkg::OP_LOAD;
                    n_state  = S_TRIG;
                    n_cnt    = '0;
                end
            end
            S_TRIG: begin
                o_cmd.op = vdsr_pkg::OP_TRIG;
                if (r_cnt == vdsr_pkg::CNT_W'(vdsr_pkg::TRIG_LAST)) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.op = vdsr_pkg::OP_MUL;
                if (r_cnt == vdsr_pkg::CNT_W'(vdsr_pkg::MUL_LAST)) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                    n_axis  = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.op = vdsr_pkg::OP_DIV;
                if (r_cnt == vdsr_pkg::CNT_W'(vdsr_pkg::DIV_STEPS)) begin
                    n_state = S_TM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TM: begin
                o_cmd.op = vdsr_pkg::OP_TM;
                n_cnt    = '0;
                if (r_axis == 2'(vdsr_pkg::AXIS_LAST)) begin
                    n_state = S_WALK;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DIV;
                end
            end
            S_WALK: begin
                o_cmd.op = vdsr_pkg::OP_WALK;
                if (i_status.hit || r_cnt == vdsr_pkg::CNT_W'(vdsr_pkg::MAX_STEPS - 1)) begin
                    n_state = S_SHADE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SHADE: begin
                // hold until the output register can take the result
                if (!i_status.out_busy) begin
                    o_cmd.op = vdsr_pkg::OP_SHADE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/vdsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdsr_dp
// Datapath: frame register, rotation MAC, radix-2 divider, DDA walk, shading.
// ----------------------------------------------------------------------------
module vdsr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vdsr_pkg::t_dp_cmd                  i_cmd,
    input  vdsr_pkg::t_pixel                   i_pixel,
    input  logic                              i_cfg_valid,
    input  logic [vdsr_pkg::FRAME_W-1:0]       i_cfg_data,
    input  logic                              i_stall,
    output vdsr_pkg::t_dp_status               o_status,
    output logic                              o_valid,
    output vdsr_pkg::t_color                   o_color
);

    localparam int VW = vdsr_pkg::VOX_W;

    logic [vdsr_pkg::FRAME_W-1:0]          r_frame;
    logic signed [vdsr_pkg::VIEW_W-1:0]    r_vx, r_vy;
    logic [vdsr_pkg::TAB_AW-1:0]           r_idx [3];
    logic signed [vdsr_pkg::TRIG_W-1:0]    r_cs0, r_ss0, r_cs1, r_ss1;
    logic signed [vdsr_pkg::PROD_W-1:0]    r_prod;
    logic signed [vdsr_pkg::ACC_W-1:0]     r_acc;
    logic signed [vdsr_pkg::RAY_W-1:0]     r_rx;
    logic signed [vdsr_pkg::RAY_W-1:0]     r_rd [3];
    logic [11:0]                           r_brd2;
    logic [vdsr_pkg::RAY_W-1:0]            r_rem, r_dvs;
    logic [vdsr_pkg::INV_W-1:0]            r_q, r_dvd;
    logic signed [vdsr_pkg::TM_W-1:0]      r_tm [3];
    logic signed [vdsr_pkg::TM_W-1:0]      r_dt [3];
    logic [2:0]                            r_neg;
    logic signed [VW-1:0]                  r_v [3];
    logic [7:0]                            r_dist;
    logic [5:0]                            r_clr;
    vdsr_pkg::t_color                      r_color;
    logic                                  r_ovalid;

    // index arithmetic on the frame number
    logic [21:0] w_f3;
    logic [23:0] w_f9;
    assign w_f3 = {2'b00, r_frame} + {1'b0, r_frame, 1'b0};
    assign w_f9 = {4'b0000, r_frame} + {1'b0, r_frame, 3'b000};

    // rotation multiplier
    logic signed [vdsr_pkg::RAY_W-1:0]  w_ma;
    logic signed [vdsr_pkg::TRIG_W-1:0] w_mb;
    logic signed [vdsr_pkg::ACC_W-1:0]  w_pext, w_sub, w_add;
    logic signed [vdsr_pkg::ACC_W-1:0]  w_sub_sh, w_add_sh;

    always_comb begin
        case (i_cmd.cnt[2:0])
            3'd0: begin w_ma = vdsr_pkg::RAY_W'(r_vx); w_mb = r_cs1; end
            3'd1: begin w_ma = vdsr_pkg::RAY_W'(r_vy); w_mb = r_ss1; end
            3'd2: begin w_ma = vdsr_pkg::RAY_W'(r_vx); w_mb = r_ss1; end
            3'd3: begin w_ma = vdsr_pkg::RAY_W'(r_vy); w_mb = r_cs1; end
            3'd4: begin w_ma = r_rx; w_mb = r_cs0; end
            3'd5: begin w_ma = vdsr_pkg::RAY_W'(vdsr_pkg::VIEW_Z); w_mb = r_ss0; end
            3'd6: begin w_ma = r_rx; w_mb = r_ss0; end
            default: begin w_ma = vdsr_pkg::RAY_W'(vdsr_pkg::VIEW_Z); w_mb = r_cs0; end
        endcase
    end

    assign w_pext   = vdsr_pkg::ACC_W'(r_prod);
    assign w_sub    = r_acc - w_pext;
    assign w_add    = r_acc + w_pext;
    assign w_sub_sh = w_sub >>> vdsr_pkg::FX_SHIFT;
    assign w_add_sh = w_add >>> vdsr_pkg::FX_SHIFT;

    // divider step
    logic [vdsr_pkg::RAY_W:0]   w_rem_sh;
    logic                       w_ge;
    logic signed [vdsr_pkg::RAY_W-1:0] w_rd_sel;
    assign w_rd_sel = r_rd[i_cmd.axis];
    assign w_rem_sh = {r_rem, r_dvd[vdsr_pkg::INV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    // first crossing time for the selected axis
    logic [vdsr_pkg::INV_W-1:0] w_inv;
    logic [11:0]                w_brd;
    logic [12:0]                w_fac;
    logic [31:0]                w_tprod;
    assign w_inv   = (w_rd_sel == '0) ? vdsr_pkg::INV_W'(vdsr_pkg::RECIP_ZERO) : r_q;
    assign w_brd   = (i_cmd.axis == 2'(vdsr_pkg::AXIS_LAST)) ? r_brd2 : 12'd0;
    assign w_fac   = w_rd_sel[vdsr_pkg::RAY_W-1] ? {1'b0, w_brd}
                                                 : 13'(vdsr_pkg::CELL_ONE) - {1'b0, w_brd};
    assign w_tprod = 32'(w_fac) * 32'(w_inv);

    // traversal
    logic       w_hit;
    logic [1:0] w_ax;
    logic [5:0] w_tex;
    assign w_hit = vdsr_pkg::solid(r_v[0], r_v[1], r_v[2]);
    assign w_tex = r_v[0][5:0] ^ r_v[1][5:0] ^ r_v[2][5:0];
    always_comb begin
        if (r_tm[0] <= r_tm[1] && r_tm[0] <= r_tm[2]) begin
            w_ax = 2'd0;
        end else if (r_tm[1] < r_tm[0] && r_tm[1] < r_tm[2]) begin
            w_ax = 2'd1;
        end else begin
            w_ax = 2'd2;
        end
    end

    // shading
    logic [8:0]  w_light;
    logic [14:0] w_shade;
    logic [7:0]  w_rg, w_b;
    assign w_light = 9'd256 - {1'b0, r_dist};
    assign w_shade = 15'(w_light) * 15'(r_clr);
    assign w_rg    = w_shade[14:7] + r_dist;
    assign w_b     = 8'(w_shade[14:8]) + r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_frame <= i_cfg_data;
            end
            if (i_cmd.op == vdsr_pkg::OP_SHADE) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            vdsr_pkg::OP_LOAD: begin
                r_vx     <= $signed({2'b00, i_pixel.pixel_column})
                          - vdsr_pkg::VIEW_W'(vdsr_pkg::HALF_WIDTH);
                r_vy     <= $signed({2'b00, i_pixel.pixel_row})
                          - vdsr_pkg::VIEW_W'(vdsr_pkg::HALF_HEIGHT);
                r_idx[0] <= r_frame[vdsr_pkg::TAB_AW:1];
                r_idx[1] <= w_f3[vdsr_pkg::TAB_AW+2:3];
                r_idx[2] <= w_f9[vdsr_pkg::TAB_AW+3:4];
                r_brd2   <= {r_frame[2:0], 9'd0};
                r_v[0]   <= VW'(vdsr_pkg::START_X >>> vdsr_pkg::CELL_SH);
                r_v[1]   <= VW'(vdsr_pkg::START_Y >>> vdsr_pkg::CELL_SH);
                r_v[2]   <= VW'(r_frame[vdsr_pkg::FRAME_W-1:3]);
            end
            vdsr_pkg::OP_TRIG: begin
                case (i_cmd.cnt[1:0])
                    2'd0: begin
                        r_cs0 <= vdsr_pkg::TRIG_ROM[r_idx[0]][2*vdsr_pkg::TRIG_W-1:vdsr_pkg::TRIG_W];
                        r_ss0 <= vdsr_pkg::TRIG_ROM[r_idx[0]][vdsr_pkg::TRIG_W-1:0];
                    end
                    2'd1: begin
                        r_cs1 <= vdsr_pkg::TRIG_ROM[r_idx[1]][2*vdsr_pkg::TRIG_W-1:vdsr_pkg::TRIG_W];
                    end
                    default: begin
                        r_ss1 <= vdsr_pkg::TRIG_ROM[r_idx[2]][vdsr_pkg::TRIG_W-1:0];
                    end
                endcase
            end
            vdsr_pkg::OP_MUL: begin
                r_prod <= w_ma * w_mb;
                // fold the previous product: load, subtract or add and scale
                case (i_cmd.cnt[3:0])
                    4'd1, 4'd3, 4'd5, 4'd7: r_acc <= w_pext;
                    4'd2: r_rx    <= w_sub_sh[vdsr_pkg::RAY_W-1:0];
                    4'd4: r_rd[1] <= w_add_sh[vdsr_pkg::RAY_W-1:0];
                    4'd6: r_rd[0] <= w_sub_sh[vdsr_pkg::RAY_W-1:0];
                    4'd8: r_rd[2] <= w_add_sh[vdsr_pkg::RAY_W-1:0];
                    default: r_acc <= r_acc;
                endcase
            end
            vdsr_pkg::OP_DIV: begin
                if (i_cmd.cnt == '0) begin
                    r_rem <= '0;
                    r_q   <= '0;
                    r_dvd <= vdsr_pkg::INV_W'(1) << (vdsr_pkg::INV_W - 1);
                    r_dvs <= w_rd_sel[vdsr_pkg::RAY_W-1] ? vdsr_pkg::RAY_W'(-w_rd_sel)
                                                         : vdsr_pkg::RAY_W'(w_rd_sel);
                end else begin
                    r_rem <= w_ge ? vdsr_pkg::RAY_W'(w_rem_sh - {1'b0, r_dvs})
                                  : vdsr_pkg::RAY_W'(w_rem_sh);
                    r_q   <= {r_q[vdsr_pkg::INV_W-2:0], w_ge};
                    r_dvd <= r_dvd << 1;
                end
            end
            vdsr_pkg::OP_TM: begin
                r_tm[i_cmd.axis]  <= vdsr_pkg::TM_W'(w_tprod[31:vdsr_pkg::CELL_SH]);
                r_dt[i_cmd.axis]  <= vdsr_pkg::TM_W'(w_inv) - 1;
                r_neg[i_cmd.axis] <= w_rd_sel[vdsr_pkg::RAY_W-1];
            end
            vdsr_pkg::OP_WALK: begin
                if (w_hit) begin
                    r_dist <= i_cmd.cnt;
                    r_clr  <= w_tex;
                end else begin
                    r_dist <= 8'(vdsr_pkg::NO_HIT);
                    r_clr  <= '0;
                    r_v[w_ax]  <= r_neg[w_ax] ? VW'(r_v[w_ax] - 1) : VW'(r_v[w_ax] + 1);
                    r_tm[w_ax] <= r_tm[w_ax] + r_dt[w_ax];
                end
            end
            vdsr_pkg::OP_SHADE: begin
                r_color.red   <= w_rg;
                r_color.green <= w_rg;
                r_color.blue  <= w_b;
            end
            default: begin
                r_color <= r_color;
            end
        endcase
    end

    assign o_status.hit      = w_hit;
    assign o_status.out_busy = r_ovalid && i_stall;
    assign o_valid           = r_ovalid;
    assign o_color           = r_color;

endmodule

FILE: rtl/core/voxel_dda_sponge_raycaster.sv
`timescale 1ns / 1ps
// Sequence: table reads, rotation products, a reciprocal and first crossing time per
//   axis, traversal until a hit or the step limit, then the shade that sets o_valid.
// Throughput: one pixel in flight; the next request is taken the cycle after the
//   shade; a stalled result holds the shade and input.
// Reset: synchronous active low; clears the sequencer, the output valid and
//   frame_number to 0.
// ----------------------------------------------------------------------------
// voxel_dda_sponge_raycaster
// Per-pixel voxel ray caster through a three-level sponge tile pattern.
// ----------------------------------------------------------------------------
module voxel_dda_sponge_raycaster (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  vdsr_pkg::t_pixel                i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output vdsr_pkg::t_color                o_color,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vdsr_pkg::FRAME_W-1:0]    i_cfg_data
);

    vdsr_pkg::t_dp_cmd    w_cmd;
    vdsr_pkg::t_dp_status w_status;

    vdsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_stall)
    );

    vdsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_pixel     (i_pixel),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_color     (o_color)
    );

    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/core/vdsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdsr_checker
// Port-level checks for the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_dda_sponge_raycaster_assert.svh"

module vdsr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input vdsr_pkg::t_color             o_color
);

    `VDSR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "request accepted but block not busy")
    `VDSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_color), "stalled result changed")
    `VDSR_ASSERT_NOW(a_red_eq_green, i_clk, i_rst_n, o_valid, o_color.red == o_color.green, "red and green differ")
    `VDSR_ASSERT_NOW(a_blue_le_red, i_clk, i_rst_n, o_valid, o_color.blue <= o_color.red, "blue exceeds red")

endmodule

bind voxel_dda_sponge_raycaster vdsr_checker u_vdsr_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster pixel testbench
// Sends pixels through voxel_dda_sponge_raycaster under several frame numbers
// and random idling on both sides. Each returned color is checked against an
// in-bench model: it rotates the view ray, walks the voxel grid and shades it.
// ----------------------------------------------------------------------------
module tb;

    localparam int     LATENCY_WAIT = 360;
    localparam longint CYCLE_LIMIT  = 4_000_000;
    localparam longint Q60_ONE      = 64'sh1000000000000000;
    localparam longint Q60_HALF_PI  = 64'sh1921FB54442D1847;

    typedef struct {
        int col;
        int row;
    } t_pixel_row;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    vdsr_pkg::t_pixel              i_pixel     = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    vdsr_pkg::t_color              o_color;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [vdsr_pkg::FRAME_W-1:0]  i_cfg_data  = '0;

    vdsr_pkg::t_color              color_q[$];
    logic [vdsr_pkg::FRAME_W-1:0]  frame_cur   = '0;
    int                  send_idle   = 0;
    int                  recv_idle   = 0;
    int                  errors      = 0;
    int                  n_sent      = 0;
    int                  n_checked   = 0;
    int                  n_frames    = 0;
    int                  hold_left   = 0;
    bit                  hold_req    = 1'b0;
    longint              cycles      = 0;

    t_pixel_row corner_rows[12] = '{
        '{0, 0}, '{1919, 1079}, '{2047, 2047}, '{960, 540}, '{0, 2047},
        '{2047, 0}, '{1919, 0}, '{0, 1079}, '{960, 0}, '{0, 540},
        '{1024, 1024}, '{1365, 682}
    };

    voxel_dda_sponge_raycaster u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_color    (o_color),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint q60_mul(input longint a, input longint b);
        logic [127:0]    prod;
        longint unsigned mag;
        prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        mag  = 64'(prod >> 60);
        return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint to_1024(input longint x);
        longint mag;
        mag = (x < 0 ? -x : x) >>> 50;
        return x < 0 ? -mag : mag;
    endfunction

    // cos and sin of 2*3.14159*k/512, scaled by 1024 and truncated
    task automatic angle_1024(input longint unsigned k, output longint cv, output longint sv);
        longint unsigned n;
        longint          r;
        longint          c;
        longint          s;
        longint          t;
        int              quad;
        n    = 314159 * (k & 511);
        r    = longint'(((n / 3125) << 47) + (((n % 3125) << 47) / 3125));
        c    = Q60_ONE;
        s    = 0;
        t    = Q60_ONE;
        quad = 0;
        while (r > (Q60_HALF_PI >>> 1)) begin
            r    = r - Q60_HALF_PI;
            quad = quad + 1;
        end
        for (int j = 1; j <= 22; j++) begin
            t = q60_mul(t, r) / longint'(j);
            case (j % 4)
                1: s = s + t;
                2: c = c - t;
                3: s = s - t;
                default: c = c + t;
            endcase
        end
        case (quad % 4)
            0: begin cv = to_1024(c);  sv = to_1024(s);  end
            1: begin cv = to_1024(-s); sv = to_1024(c);  end
            2: begin cv = to_1024(-c); sv = to_1024(-s); end
            default: begin cv = to_1024(s); sv = to_1024(-c); end
        endcase
    endtask

    function automatic bit voxel_filled(input longint x, input longint y, input longint z);
        int on_face;
        for (int lv = 0; lv < 3; lv++) begin
            on_face = 0;
            on_face += (((x >> (2 * lv)) & 3) inside {0, 3});
            on_face += (((y >> (2 * lv)) & 3) inside {0, 3});
            on_face += (((z >> (2 * lv)) & 3) inside {0, 3});
            if (on_face < 2) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic cast_pixel(input int col, input int row,
                              input logic [vdsr_pkg::FRAME_W-1:0] frame,
                              output vdsr_pkg::t_color rgb);
        longint f;
        longint c0, s0, c1, s1, unused;
        longint vx, vy, rx, ry, inv, frac;
        longint dir[3], pos[3], vox[3], stp[3], tmax[3], tdel[3];
        longint hit_step, tex, shade;
        int     ax;
        f  = longint'(frame);
        vx = longint'(col) - vdsr_pkg::SCREEN_WIDTH / 2;
        vy = longint'(row) - vdsr_pkg::SCREEN_HEIGHT / 2;
        angle_1024(longint'(f >>> 1), c0, s0);
        angle_1024(longint'((f * 3) >>> 3), c1, unused);
        angle_1024(longint'((f * 9) >>> 4), unused, s1);
        rx     = (vx * c1 - vy * s1) >>> 10;
        ry     = (vx * s1 + vy * c1) >>> 10;
        dir[0] = (rx * c0 - 384 * s0) >>> 10;
        dir[1] = ry;
        dir[2] = (rx * s0 + 384 * c0) >>> 10;
        pos[0] = 68 << 11;
        pos[1] = 12 << 11;
        pos[2] = f << 9;
        for (int a = 0; a < 3; a++) begin
            inv     = (dir[a] == 0) ? ((1 << 17) - 1)
                                    : ((1 << 18) / (dir[a] < 0 ? -dir[a] : dir[a]));
            vox[a]  = pos[a] >>> 12;
            stp[a]  = dir[a] < 0 ? -1 : 1;
            frac    = pos[a] - vox[a] * 4096;
            tmax[a] = ((dir[a] < 0 ? frac : 4096 - frac) * inv) >>> 12;
            tdel[a] = ((4096 * inv) >>> 12) - 1;
        end
        hit_step = 255;
        tex      = 0;
        for (int n = 0; n < vdsr_pkg::MAX_STEPS; n++) begin
            if (voxel_filled(vox[0], vox[1], vox[2])) begin
                tex      = (vox[0] ^ vox[1] ^ vox[2]) & 63;
                hit_step = n;
                break;
            end
            if (tmax[0] <= tmax[1] && tmax[0] <= tmax[2]) ax = 0;
            else if (tmax[1] < tmax[0] && tmax[1] < tmax[2]) ax = 1;
            else ax = 2;
            vox[ax]  += stp[ax];
            tmax[ax] += tdel[ax];
        end
        shade     = (256 - hit_step) * tex;
        rgb.red   = 8'((shade >> 7) + hit_step);
        rgb.green = 8'((shade >> 7) + hit_step);
        rgb.blue  = 8'((shade >> 8) + hit_step);
    endtask

    // result side: check, then decide the stall for the next cycle
    always @(posedge i_clk) begin
        vdsr_pkg::t_color want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (color_q.size() == 0) begin
                $error("color returned with no pixel outstanding");
                errors++;
            end else begin
                want = color_q.pop_front();
                n_checked++;
                if (o_color.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_color.red);
                    errors++;
                end
                if (o_color.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_color.green);
                    errors++;
                end
                if (o_color.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_color.blue);
                    errors++;
                end
            end
        end
        if (hold_req) begin
            hold_left = 1500;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("voxel_dda_sponge_raycaster test failed");
            $finish;
        end
    end

    // offer one request; returns at the edge where it is taken
    task automatic send_pixel(input int col, input int row);
        vdsr_pkg::t_color want;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_pixel.pixel_column <= vdsr_pkg::COORD_W'(col);
        i_pixel.pixel_row    <= vdsr_pkg::COORD_W'(row);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cast_pixel(col, row, frame_cur, want);
        color_q.push_back(want);
        n_sent++;
    endtask

    // drain, let the block settle, then write the frame number
    task automatic set_frame(input logic [vdsr_pkg::FRAME_W-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (color_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        frame_cur = value;
        n_frames++;
    endtask

    task automatic random_pixels(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                send_pixel($urandom_range(2047), $urandom_range(2047));
            else
                send_pixel($urandom_range(vdsr_pkg::SCREEN_WIDTH - 1),
                           $urandom_range(vdsr_pkg::SCREEN_HEIGHT - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners and center at reset frame, then at the largest frame
        foreach (corner_rows[k]) send_pixel(corner_rows[k].col, corner_rows[k].row);
        set_frame('1);
        foreach (corner_rows[k]) send_pixel(corner_rows[k].col, corner_rows[k].row);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 21 : (mode == 1) ? 62 : 0;
            recv_idle = (mode == 0) ? 62 : (mode == 1) ? 21 : 0;
            set_frame(mode == 0 ? 20'd1 : vdsr_pkg::FRAME_W'($urandom_range(1048575)));
            random_pixels(250);
            set_frame(mode == 2 ? 20'd0 : vdsr_pkg::FRAME_W'($urandom_range(1048575)));
            if (mode == 2) begin
                // block the output long enough that the input backs up
                hold_req = 1'b1;
                random_pixels(30);
            end
            random_pixels(mode == 2 ? 220 : 250);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (color_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);

        $display("Sent %0d pixels under %0d frame settings; %0d colors checked, %0d errors.",
                 n_sent, n_frames + 1, n_checked, errors);
        if (errors == 0)
            $display("voxel_dda_sponge_raycaster test passed");
        else
            $display("voxel_dda_sponge_raycaster test failed");
        $finish;
    end
endmodule
